[rtl/core/ssf_pkg.sv]
// Shared constants, controller states and command/status types for the top-fraction selector.
package ssf_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int MARK_W          = 32;
   localparam int INDEX_W         = 6;
   localparam int PCT_W           = 7;
   localparam int PCT_FULL        = 100;
   localparam int PCT_RESET       = 50;

   // floor(p / 100) == (p * PCT_RECIP) >> PCT_SHIFT for all p below 199728
   localparam int PCT_SHIFT       = 24;
   localparam int PCT_RECIP       = 167773;
   localparam int RECIP_W         = 18;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_KEY_RD,
      ST_KEY_LATCH,
      ST_CMP,
      ST_PLACE,
      ST_MUL1,
      ST_MUL2,
      ST_EMIT_RD,
      ST_EMIT_LOAD,
      ST_EMIT_WAIT
   } state_type;

   typedef struct packed {
      logic load;       // store the offered entry
      logic key_rd;     // read entry i
      logic key_latch;  // capture key, read entry j-1
      logic shift;      // move entry j-1 up to j
      logic place;      // drop key at j, advance i
      logic mul1;       // n * percent
      logic mul2;       // divide by one hundred
      logic emit_rd;    // read next entry from the top
      logic emit_load;  // fill the result register
      logic clear;      // empty the set
   } cmd_type;

   typedef struct packed {
      logic sort_done;  // i reached n
      logic less;       // key below entry j-1
      logic j_one;      // j is 1
      logic emit_done;  // no results left
      logic rsp_taken;  // result transfer this cycle
   } sts_type;

endpackage

[rtl/core/ssf_req_if.sv]
// Input channel: one fitness mark per transfer with an end-of-set flag.
interface ssf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ssf_pkg::MARK_W-1:0]    mark;
   logic                                 last;

   modport source (output valid, output mark, output last, input ready);
   modport sink   (input valid, input mark, input last, output ready);
endinterface

[rtl/core/ssf_rsp_if.sv]
// Result channel: one selected entry per transfer.
interface ssf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic        [ssf_pkg::INDEX_W-1:0]   entry_index;
   logic signed [ssf_pkg::MARK_W-1:0]    entry_mark;
   logic                                 final_res;

   modport source (output valid, output entry_index, output entry_mark, output final_res,
                   input ready);
   modport sink   (input valid, input entry_index, input entry_mark, input final_res,
                   output ready);
endinterface

[rtl/core/ssf_ctrl.sv]
// Controller state machine: load, insertion sort, count, emit.
module ssf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_ready,
   output ssf_pkg::cmd_type cmd,
   input  ssf_pkg::sts_type sts
);

   ssf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssf_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssf_pkg::ST_LOAD: begin
            if (req_valid && req_last) state_in = ssf_pkg::ST_KEY_RD;
         end
         ssf_pkg::ST_KEY_RD: begin
            state_in = sts.sort_done ? ssf_pkg::ST_MUL1 : ssf_pkg::ST_KEY_LATCH;
         end
         ssf_pkg::ST_KEY_LATCH: state_in = ssf_pkg::ST_CMP;
         ssf_pkg::ST_CMP: begin
            if (!sts.less || sts.j_one) state_in = ssf_pkg::ST_PLACE;
         end
         ssf_pkg::ST_PLACE:     state_in = ssf_pkg::ST_KEY_RD;
         ssf_pkg::ST_MUL1:      state_in = ssf_pkg::ST_MUL2;
         ssf_pkg::ST_MUL2:      state_in = ssf_pkg::ST_EMIT_RD;
         ssf_pkg::ST_EMIT_RD: begin
            state_in = sts.emit_done ? ssf_pkg::ST_LOAD : ssf_pkg::ST_EMIT_LOAD;
         end
         ssf_pkg::ST_EMIT_LOAD: state_in = ssf_pkg::ST_EMIT_WAIT;
         ssf_pkg::ST_EMIT_WAIT: begin
            if (sts.rsp_taken) state_in = ssf_pkg::ST_EMIT_RD;
         end
         default:               state_in = ssf_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ssf_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ssf_pkg::ST_KEY_RD:    cmd.key_rd    = !sts.sort_done;
         ssf_pkg::ST_KEY_LATCH: cmd.key_latch = 1'b1;
         ssf_pkg::ST_CMP:       cmd.shift     = sts.less;
         ssf_pkg::ST_PLACE:     cmd.place     = 1'b1;
         ssf_pkg::ST_MUL1:      cmd.mul1      = 1'b1;
         ssf_pkg::ST_MUL2:      cmd.mul2      = 1'b1;
         ssf_pkg::ST_EMIT_RD: begin
            cmd.emit_rd = !sts.emit_done;
            cmd.clear   = sts.emit_done;
         end
         ssf_pkg::ST_EMIT_LOAD: cmd.emit_load = 1'b1;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

[rtl/core/ssf_dp.sv]
// Datapath: entry memory, sort registers, count arithmetic and result register.
module ssf_dp #(
   parameter int MAX_ENTRIES = ssf_pkg::MAX_ENTRIES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ssf_pkg::cmd_type                     cmd,
   output ssf_pkg::sts_type                     sts,
   input  logic signed [ssf_pkg::MARK_W-1:0]    req_mark,
   input  logic                                 csr_we,
   input  logic        [ssf_pkg::PCT_W-1:0]     csr_wdata,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic        [ssf_pkg::INDEX_W-1:0]   rsp_entry_index,
   output logic signed [ssf_pkg::MARK_W-1:0]    rsp_entry_mark,
   output logic                                 rsp_final_res
);

   localparam int ADDR_W  = $clog2(MAX_ENTRIES);
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int PROD_W  = $clog2(MAX_ENTRIES * ssf_pkg::PCT_FULL + 1);
   localparam int WIDE_W  = PROD_W + ssf_pkg::RECIP_W;
   localparam int ENTRY_W = ssf_pkg::INDEX_W + ssf_pkg::MARK_W;

   // entry layout: {index, mark}
   logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
   logic [ENTRY_W-1:0] rdata_ff;
   logic [ADDR_W-1:0]  raddr;
   logic               mem_we;
   logic [ADDR_W-1:0]  waddr;
   logic [ENTRY_W-1:0] wdata;

   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [CNT_W-1:0]           i_ff, i_in;
   logic [ADDR_W-1:0]          j_ff, j_in;
   logic [ENTRY_W-1:0]         key_ff, key_in;
   logic [ssf_pkg::PCT_W-1:0]  pct_ff, pct_in;
   logic [ssf_pkg::PCT_W-1:0]  pct_sat;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [WIDE_W-1:0]          wide;
   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic [ADDR_W-1:0]          pos_ff, pos_in;
   logic                       full;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ssf_pkg::INDEX_W-1:0]       rsp_index_ff, rsp_index_in;
   logic [ssf_pkg::MARK_W-1:0]        rsp_mark_ff, rsp_mark_in;
   logic                              rsp_final_ff, rsp_final_in;

   assign full    = (cnt_ff == CNT_W'(MAX_ENTRIES));
   assign pct_sat = (pct_ff > ssf_pkg::PCT_W'(ssf_pkg::PCT_FULL)) ?
                    ssf_pkg::PCT_W'(ssf_pkg::PCT_FULL) : pct_ff;
   assign wide    = WIDE_W'(prod_ff) * WIDE_W'(ssf_pkg::PCT_RECIP);

   assign sts.sort_done = (i_ff >= cnt_ff);
   assign sts.less      = $signed(key_ff[ssf_pkg::MARK_W-1:0]) <
                          $signed(rdata_ff[ssf_pkg::MARK_W-1:0]);
   assign sts.j_one     = (j_ff == ADDR_W'(1));
   assign sts.emit_done = (rem_ff == '0);
   assign sts.rsp_taken = rsp_valid_ff && rsp_ready;

   // memory read address
   always_comb begin
      raddr = '0;
      if (cmd.key_rd)         raddr = i_ff[ADDR_W-1:0];
      else if (cmd.key_latch) raddr = i_ff[ADDR_W-1:0] - ADDR_W'(1);
      else if (cmd.shift)     raddr = j_ff - ADDR_W'(2);
      else if (cmd.emit_rd)   raddr = pos_ff;
   end

   // memory write port
   always_comb begin
      mem_we = 1'b0;
      waddr  = j_ff;
      wdata  = key_ff;
      if (cmd.load && !full) begin
         mem_we = 1'b1;
         waddr  = cnt_ff[ADDR_W-1:0];
         wdata  = {ssf_pkg::INDEX_W'(cnt_ff), req_mark};
      end else if (cmd.shift) begin
         mem_we = 1'b1;
         wdata  = rdata_ff;
      end else if (cmd.place) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_comb begin
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      key_in       = key_ff;
      pct_in       = csr_we ? csr_wdata : pct_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_mark_in  = rsp_mark_ff;
      rsp_final_in = rsp_final_ff;
      if (cmd.load) begin
         i_in = CNT_W'(1);
         if (!full) cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.key_latch) begin
         key_in = rdata_ff;
         j_in   = i_ff[ADDR_W-1:0];
      end
      if (cmd.shift) j_in = j_ff - ADDR_W'(1);
      if (cmd.place) i_in = i_ff + CNT_W'(1);
      if (cmd.mul1) begin
         prod_in = PROD_W'(cnt_ff) * PROD_W'(pct_sat);
         pos_in  = ADDR_W'(cnt_ff - CNT_W'(1));
      end
      if (cmd.mul2) rem_in = wide[ssf_pkg::PCT_SHIFT +: CNT_W];
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = rdata_ff[ENTRY_W-1 -: ssf_pkg::INDEX_W];
         rsp_mark_in  = rdata_ff[ssf_pkg::MARK_W-1:0];
         rsp_final_in = (rem_ff == CNT_W'(1));
         rem_in       = rem_ff - CNT_W'(1);
         pos_in       = pos_ff - ADDR_W'(1);
      end
      if (cmd.clear) cnt_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pct_ff       <= ssf_pkg::PCT_W'(ssf_pkg::PCT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pct_ff       <= pct_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      key_ff       <= key_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      pos_ff       <= pos_in;
      rsp_index_ff <= rsp_index_in;
      rsp_mark_ff  <= rsp_mark_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_entry_mark  = $signed(rsp_mark_ff);
   assign rsp_final_res   = rsp_final_ff;

endmodule

[rtl/core/sort_and_select_top_fraction_unit.sv]
// Top level of the top-fraction selector: controller plus datapath.
//
//   channel   direction  handshake        payload
//   req_if    in         valid / ready    mark (Q16.16 signed), last
//   rsp_if    out        valid / ready    entry_index, entry_mark, final_res
//   csr       in         csr_we           csr_wdata = top_percent (7 bits)
//
// Loading accepts one entry per cycle. After the transfer that carries last, an
// insertion sort runs in the entry memory through its single read port. The
// count is then formed by a multiply and a reciprocal multiply, and each result
// is read from the memory, loaded into the result register and held there until
// rsp_if takes it; req_if is held not ready until the last result has gone.
// Reset is synchronous; it empties the set and restores top_percent to 50. The
// memory needs no clearing.
module sort_and_select_top_fraction_unit #(
   parameter int MAX_ENTRIES = ssf_pkg::MAX_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   ssf_req_if.sink                         req_if,
   ssf_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [ssf_pkg::PCT_W-1:0]       csr_wdata
);

   ssf_pkg::cmd_type cmd;
   ssf_pkg::sts_type sts;

   // sequencing: accept entries, then walk sort, count and emit steps
   ssf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last),
      .req_ready (req_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // storage and arithmetic; holds the result until its transfer
   ssf_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mark        (req_if.mark),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_entry_index (rsp_if.entry_index),
      .rsp_entry_mark  (rsp_if.entry_mark),
      .rsp_final_res   (rsp_if.final_res)
   );

endmodule
